/* rtl/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int ADDR_W    = 28;
  localparam int COUNT_W   = 17;
  localparam int STATUS_W  = 2;
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;

  localparam int NUM_FRAMES_DEF = 65536;
  localparam int PAGE_BYTES_DEF = 4096;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FRAME  = 2'd1,
    ST_BAD_COUNT = 2'd2,
    ST_PAST_END  = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef struct packed {
    logic               req_type;
    logic [ADDR_W-1:0]  frame_addr;
    logic [COUNT_W-1:0] page_count;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   granted_addr;
  } out_item_t;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_SCAN_RD,
    CS_SCAN_CHK,
    CS_FREE_RD,
    CS_FREE_WR,
    CS_RESP
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic    load_req;
    logic    clr_wr;
    logic    scan_rd;
    logic    hint_inc;
    logic    alloc_wr;
    logic    free_rd;
    logic    free_wr;
    logic    word_inc;
    logic    out_load;
    logic    out_grant;
    status_t out_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_free;
    logic in_cnt_one;
    logic in_nowalk;
    logic in_past_end;
    logic hint_end;
    logic word_full;
    logic walk_last;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/bitmap_frame_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit page frame allocator over a one-bit-per-frame used map.
// ----------------------------------------------------------------------------
//  channel | dir | payload      | handshake
//  in_     | in  | in_item_t    | in_valid / in_stall
//  out_    | out | out_item_t   | out_valid / out_stall
//
//  Bad-count and empty requests go straight to the response. An allocate
//  reads map words from the scan hint upward until one has a free frame or
//  the hint reaches the end of the map; a free reads and writes back each
//  map word touched by the run. The map RAM has a single registered read
//  port. After reset a clearing pass writes every map word to all used,
//  one word per cycle, with in_stall high. A result waits in the output
//  register while out_stall is high; the next request is still taken and
//  held until the register frees.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator #(
  parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BYTES = bfa_pkg::PAGE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bfa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bfa_pkg::out_item_t out_data
);

  bfa_pkg::cmd_t cmd;
  bfa_pkg::sts_t sts;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  bfa_dpath #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a transfer in always leaves the block busy in the cycle after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken back to back");

  // a fresh result is only loaded while a request is in progress
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no request in progress");

  // only a successful allocation carries an address
  a_addr_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.granted_addr != '0) |-> out_data.status == bfa_pkg::ST_OK)
    else $error("address returned with failing status");

  // no result is loaded before the map clearing pass is done
  a_no_load_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !cmd.out_load && !cmd.load_req)
    else $error("request handled during clearing pass");

endmodule

/* rtl/bfa_ram.sv */
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/bfa_ctrl.sv */
// ----------------------------------------------------------------------------
// bfa_ctrl
// Request sequencer: clearing pass, first-fit scan, free walk, response.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output bfa_pkg::cmd_t cmd,
  input  bfa_pkg::sts_t sts
);

  bfa_pkg::ctrl_state_t state_r, state_nxt;
  bfa_pkg::status_t     resp_code_r, resp_code_nxt;
  logic                 resp_grant_r, resp_grant_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bfa_pkg::CS_CLEAR;
      resp_code_r  <= bfa_pkg::ST_OK;
      resp_grant_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      resp_code_r  <= resp_code_nxt;
      resp_grant_r <= resp_grant_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    resp_code_nxt  = resp_code_r;
    resp_grant_nxt = resp_grant_r;
    cmd            = '0;
    cmd.out_status = resp_code_r;
    cmd.out_grant  = resp_grant_r;
    in_stall       = (state_r != bfa_pkg::CS_IDLE);

    unique case (state_r)
      bfa_pkg::CS_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = bfa_pkg::CS_IDLE;
        end
      end
      bfa_pkg::CS_IDLE: begin
        if (in_valid) begin
          cmd.load_req   = 1'b1;
          resp_grant_nxt = 1'b0;
          if (sts.in_free) begin
            resp_code_nxt = sts.in_past_end ? bfa_pkg::ST_PAST_END : bfa_pkg::ST_OK;
            state_nxt     = sts.in_nowalk ? bfa_pkg::CS_RESP : bfa_pkg::CS_FREE_RD;
          end else if (!sts.in_cnt_one) begin
            resp_code_nxt = bfa_pkg::ST_BAD_COUNT;
            state_nxt     = bfa_pkg::CS_RESP;
          end else begin
            state_nxt = bfa_pkg::CS_SCAN_RD;
          end
        end
      end
      bfa_pkg::CS_SCAN_RD: begin
        if (sts.hint_end) begin
          resp_code_nxt = bfa_pkg::ST_NO_FRAME;
          state_nxt     = bfa_pkg::CS_RESP;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = bfa_pkg::CS_SCAN_CHK;
        end
      end
      bfa_pkg::CS_SCAN_CHK: begin
        if (sts.word_full) begin
          cmd.hint_inc = 1'b1;
          state_nxt    = bfa_pkg::CS_SCAN_RD;
        end else begin
          cmd.alloc_wr   = 1'b1;
          resp_code_nxt  = bfa_pkg::ST_OK;
          resp_grant_nxt = 1'b1;
          state_nxt      = bfa_pkg::CS_RESP;
        end
      end
      bfa_pkg::CS_FREE_RD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = bfa_pkg::CS_FREE_WR;
      end
      bfa_pkg::CS_FREE_WR: begin
        cmd.free_wr = 1'b1;
        if (sts.walk_last) begin
          state_nxt = bfa_pkg::CS_RESP;
        end else begin
          cmd.word_inc = 1'b1;
          state_nxt    = bfa_pkg::CS_FREE_RD;
        end
      end
      bfa_pkg::CS_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = bfa_pkg::CS_IDLE;
        end
      end
      default: begin
        state_nxt = bfa_pkg::CS_IDLE;
      end
    endcase
  end

endmodule

/* rtl/bfa_dpath.sv */
// ----------------------------------------------------------------------------
// bfa_dpath
// Used-bit map storage, scan hint, run walker and output register.
// ----------------------------------------------------------------------------
module bfa_dpath #(
  parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BYTES = bfa_pkg::PAGE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bfa_pkg::in_item_t   in_data,
  input  bfa_pkg::cmd_t       cmd,
  output bfa_pkg::sts_t       sts,
  output logic                out_valid,
  input  logic                out_stall,
  output bfa_pkg::out_item_t  out_data
);

  // PAGE_BYTES is a power of two
  localparam int PAGE_LOG2 = $clog2(PAGE_BYTES);
  localparam int MAP_WORDS = (NUM_FRAMES + bfa_pkg::WORD_BITS - 1) / bfa_pkg::WORD_BITS;
  localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int HINT_W    = $clog2(MAP_WORDS + 1);
  localparam int FRAME_W   = WORD_W + bfa_pkg::BIT_W;
  localparam int FIRST_W   = bfa_pkg::ADDR_W - PAGE_LOG2;
  localparam int MAX_A     = (FIRST_W > bfa_pkg::COUNT_W) ? FIRST_W : bfa_pkg::COUNT_W;
  localparam int CALC_W    = ((MAX_A > FRAME_W) ? MAX_A : FRAME_W) + 1;
  localparam int GA_W      = FRAME_W + PAGE_LOG2;
  localparam int GX_W      = (GA_W > bfa_pkg::ADDR_W) ? GA_W : bfa_pkg::ADDR_W;
  localparam int WB        = bfa_pkg::WORD_BITS;
  localparam int BW        = bfa_pkg::BIT_W;

  // request decode
  logic [bfa_pkg::ADDR_W-1:0] first_sh;
  logic [CALC_W-1:0]          first_c, endm1_c, lastm1_c;
  logic                       cnt_zero, past_end;

  assign first_sh = in_data.frame_addr >> PAGE_LOG2;
  assign first_c  = CALC_W'(first_sh);
  assign cnt_zero = (in_data.page_count == '0);
  assign endm1_c  = first_c + CALC_W'(in_data.page_count) - CALC_W'(1);
  assign past_end = !cnt_zero && (endm1_c >= CALC_W'(NUM_FRAMES));
  assign lastm1_c = past_end ? CALC_W'(NUM_FRAMES - 1) : endm1_c;

  logic [WORD_W-1:0]   first_word_r, last_word_r, wptr_r, clr_idx_r;
  logic [BW-1:0]       first_bit_r, last_bit_r;
  logic [HINT_W-1:0]   hint_r;
  logic [bfa_pkg::ADDR_W-1:0] gaddr_r;
  logic                out_valid_r;
  bfa_pkg::out_item_t  out_data_r;

  // map storage
  logic              ram_we, ram_re;
  logic [WORD_W-1:0] ram_waddr, ram_raddr;
  logic [WB-1:0]     ram_wdata, rd_data;

  bfa_ram #(
    .WIDTH (WB),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // lowest free bit of the word under scan
  logic [WB-1:0]      avail, lowest, clr_mask;
  logic [BW-1:0]      bit_idx;
  logic [FRAME_W-1:0] frame_idx;
  logic [GX_W-1:0]    gfull;
  logic               at_first, at_last;

  always_comb begin
    avail   = ~rd_data;
    lowest  = avail & (~avail + WB'(1));
    bit_idx = '0;
    for (int i = 0; i < WB; i++) begin
      if (lowest[i]) begin
        bit_idx = bit_idx | BW'(i);
      end
    end
  end

  assign frame_idx = {hint_r[WORD_W-1:0], bit_idx};
  assign gfull     = GX_W'(frame_idx) << PAGE_LOG2;

  // bits of the run that fall in the current word
  assign at_first = (wptr_r == first_word_r);
  assign at_last  = (wptr_r == last_word_r);

  always_comb begin
    for (int b = 0; b < WB; b++) begin
      clr_mask[b] = (!at_first || (BW'(b) >= first_bit_r)) &&
                    (!at_last  || (BW'(b) <= last_bit_r));
    end
  end

  always_comb begin
    ram_we    = cmd.clr_wr | cmd.alloc_wr | cmd.free_wr;
    ram_waddr = wptr_r;
    ram_wdata = rd_data & ~clr_mask;
    if (cmd.clr_wr) begin
      ram_waddr = clr_idx_r;
      ram_wdata = '1;
    end else if (cmd.alloc_wr) begin
      ram_waddr = hint_r[WORD_W-1:0];
      ram_wdata = rd_data | lowest;
    end
    ram_re    = cmd.scan_rd | cmd.free_rd;
    ram_raddr = cmd.scan_rd ? hint_r[WORD_W-1:0] : wptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      hint_r      <= HINT_W'(MAP_WORDS);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_idx_r <= clr_idx_r + WORD_W'(1);
      end
      // every word below the hint is full
      if (cmd.hint_inc) begin
        hint_r <= hint_r + HINT_W'(1);
      end else if (cmd.free_wr && (HINT_W'(wptr_r) < hint_r)) begin
        hint_r <= HINT_W'(wptr_r);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      first_word_r <= first_c[WORD_W+BW-1:BW];
      first_bit_r  <= first_c[BW-1:0];
      last_word_r  <= lastm1_c[WORD_W+BW-1:BW];
      last_bit_r   <= lastm1_c[BW-1:0];
      wptr_r       <= first_c[WORD_W+BW-1:BW];
    end else if (cmd.word_inc) begin
      wptr_r <= wptr_r + WORD_W'(1);
    end
    if (cmd.alloc_wr) begin
      gaddr_r <= gfull[bfa_pkg::ADDR_W-1:0];
    end
    if (cmd.out_load) begin
      out_data_r.status       <= cmd.out_status;
      out_data_r.granted_addr <= cmd.out_grant ? gaddr_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.in_free     = (in_data.req_type == bfa_pkg::REQ_FREE);
  assign sts.in_cnt_one  = (in_data.page_count == bfa_pkg::COUNT_W'(1));
  assign sts.in_nowalk   = cnt_zero || (first_c >= CALC_W'(NUM_FRAMES));
  assign sts.in_past_end = past_end;
  assign sts.hint_end    = (hint_r == HINT_W'(MAP_WORDS));
  assign sts.word_full   = &rd_data;
  assign sts.walk_last   = at_last;
  assign sts.clr_last    = (clr_idx_r == WORD_W'(MAP_WORDS - 1));
  assign sts.out_free    = !out_valid_r || !out_stall;

endmodule
